// ===== design/hmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Heap queue package
// Shared types and constants of the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package hmq_pkg;

  localparam int LIMIT_W  = 7;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSH_OK    = 2'd0,
    ST_PUSH_FULL  = 2'd1,
    ST_POP_OK     = 2'd2,
    ST_POP_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_LOAD,
    S_DOWN_CHK,
    S_DOWN_CMP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    push_init;
    logic    pop_read;
    logic    pop_load;
    logic    up_read;
    logic    up_move;
    logic    down_read;
    logic    down_move;
    logic    place;
    logic    set_status;
    status_t status_code;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic cmd_pop;
    logic full;
    logic empty;
    logic at_root;
    logic parent_greater;
    logic last_one;
    logic no_child;
    logic down_stay;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/hmq_in_if.sv =====
// ----------------------------------------------------------------------------
// Heap queue command channel
// Valid/ready channel that carries one push or pop command per item.
// ----------------------------------------------------------------------------
interface hmq_in_if #(
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 32
) ();

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [ID_BITS-1:0]       request_id;
  logic [PRIORITY_BITS-1:0] request_priority;

  modport source (output valid, command, request_id, request_priority, input ready);
  modport sink (input valid, command, request_id, request_priority, output ready);

endinterface

// ===== design/hmq_out_if.sv =====
// ----------------------------------------------------------------------------
// Heap queue result channel
// Valid/ready channel that carries one result item per command.
// ----------------------------------------------------------------------------
interface hmq_out_if import hmq_pkg::*; #(
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 32
) ();

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [ID_BITS-1:0]       popped_id;
  logic [PRIORITY_BITS-1:0] popped_priority;
  logic [COUNT_W-1:0]       entry_count;

  modport source (output valid, status, popped_id, popped_priority, entry_count,
                  input ready);
  modport sink (input valid, status, popped_id, popped_priority, entry_count,
                output ready);

endinterface

// ===== design/binary_min_heap_queue.sv =====
// A push rises one heap level per check and compare, and stops at the root or below a parent
// that is not greater; a pop moves the last entry to the root and sinks it level by level, unless
// it takes the last entry; a dropped push or an empty pop goes from dispatch straight to the result.
// One item at a time: the next command is accepted from the cycle in which the result is valid;
// each heap level takes a check and a compare state, and a waiting result sits in an output register meanwhile.
// Reset clears the entry count, sets the limit to 64 and leaves the heap memory as is.
// ----------------------------------------------------------------------------
// Binary min-heap priority queue
// Push and pop of requests ordered by priority, with a configurable limit.
// ----------------------------------------------------------------------------
module binary_min_heap_queue import hmq_pkg::*; #(
  parameter int CAPACITY      = 64,
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  hmq_in_if.sink             in_chan,
  hmq_out_if.source          out_chan,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hmq_datapath #(
    .CAPACITY      (CAPACITY),
    .ID_BITS       (ID_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_command          (in_chan.command),
    .in_request_id       (in_chan.request_id),
    .in_request_priority (in_chan.request_priority),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_status          (out_chan.status),
    .out_popped_id       (out_chan.popped_id),
    .out_popped_priority (out_chan.popped_priority),
    .out_entry_count     (out_chan.entry_count)
  );

endmodule

// ===== design/hmq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Heap queue controller
// State machine that sequences the sift-up and sift-down walks of the heap.
// ----------------------------------------------------------------------------
module hmq_ctrl import hmq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.cmd_pop) begin
          state_nxt = stat.empty ? S_FINISH : S_POP_LOAD;
        end else begin
          state_nxt = stat.full ? S_FINISH : S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        state_nxt = stat.at_root ? S_FINISH : S_UP_CMP;
      end
      S_UP_CMP: begin
        state_nxt = stat.parent_greater ? S_UP_CHK : S_FINISH;
      end
      S_POP_LOAD: begin
        state_nxt = stat.last_one ? S_FINISH : S_DOWN_CHK;
      end
      S_DOWN_CHK: begin
        state_nxt = stat.no_child ? S_FINISH : S_DOWN_CMP;
      end
      S_DOWN_CMP: begin
        state_nxt = stat.down_stay ? S_FINISH : S_DOWN_CHK;
      end
      S_FINISH: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_DISPATCH: begin
        if (stat.cmd_pop) begin
          if (stat.empty) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_POP_EMPTY;
          end else begin
            cmd.pop_read = 1'b1;
          end
        end else begin
          if (stat.full) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_PUSH_FULL;
          end else begin
            cmd.push_init = 1'b1;
          end
        end
      end
      S_UP_CHK: begin
        if (stat.at_root) begin
          cmd.place       = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_PUSH_OK;
        end else begin
          cmd.up_read = 1'b1;
        end
      end
      S_UP_CMP: begin
        if (stat.parent_greater) begin
          cmd.up_move = 1'b1;
        end else begin
          cmd.place       = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_PUSH_OK;
        end
      end
      S_POP_LOAD: begin
        cmd.pop_load    = 1'b1;
        cmd.set_status  = 1'b1;
        cmd.status_code = ST_POP_OK;
      end
      S_DOWN_CHK: begin
        if (stat.no_child) begin
          cmd.place = 1'b1;
        end else begin
          cmd.down_read = 1'b1;
        end
      end
      S_DOWN_CMP: begin
        if (stat.down_stay) begin
          cmd.place = 1'b1;
        end else begin
          cmd.down_move = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.load_out = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/hmq_datapath.sv =====
// ----------------------------------------------------------------------------
// Heap queue datapath
// Heap memory, entry count, moving entry, hole index and result register.
// ----------------------------------------------------------------------------
module hmq_datapath import hmq_pkg::*; #(
  parameter int CAPACITY      = 64,
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  logic                     cfg_wr_en,
  input  logic [LIMIT_W-1:0]       cfg_wr_data,
  input  logic                     in_command,
  input  logic [ID_BITS-1:0]       in_request_id,
  input  logic [PRIORITY_BITS-1:0] in_request_priority,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [ID_BITS-1:0]       out_popped_id,
  output logic [PRIORITY_BITS-1:0] out_popped_priority,
  output logic [COUNT_W-1:0]       out_entry_count
);

  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W   = ADDR_W + 2;
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int ENTRY_W = ID_BITS + PRIORITY_BITS;

  logic [ENTRY_W-1:0] mem [CAPACITY];

  logic [ENTRY_W-1:0]       rd_a_r;
  logic [ENTRY_W-1:0]       rd_b_r;
  logic [ADDR_W-1:0]        raddr_a;
  logic [ADDR_W-1:0]        raddr_b;
  logic                     mem_we;
  logic [ENTRY_W-1:0]       mem_wdata;

  logic [LIMIT_W-1:0]       limit_r;
  logic [CNT_W-1:0]         total_r;
  logic [CNT_W-1:0]         total_nxt;
  logic [ADDR_W-1:0]        hole_r;
  logic [ADDR_W-1:0]        hole_nxt;
  logic [ENTRY_W-1:0]       move_r;
  logic                     cmd_pop_r;
  status_t                  res_status_r;
  logic [ID_BITS-1:0]       res_id_r;
  logic [PRIORITY_BITS-1:0] res_prio_r;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [ID_BITS-1:0]       out_id_r;
  logic [PRIORITY_BITS-1:0] out_prio_r;
  logic [COUNT_W-1:0]       out_count_r;

  logic [ADDR_W-1:0]        parent_idx;
  logic [IDX_W-1:0]         left_w;
  logic [IDX_W-1:0]         right_w;
  logic [IDX_W-1:0]         total_w;
  logic [IDX_W-1:0]         last_w;
  logic                     right_ok;
  logic [PRIORITY_BITS-1:0] move_prio;
  logic [PRIORITY_BITS-1:0] a_prio;
  logic [PRIORITY_BITS-1:0] b_prio;
  logic [PRIORITY_BITS-1:0] min_prio;
  logic                     take_left;
  logic                     take_right;
  logic [ENTRY_W-1:0]       child;
  logic [ADDR_W-1:0]        child_idx;

  assign move_prio  = move_r[PRIORITY_BITS-1:0];
  assign a_prio     = rd_a_r[PRIORITY_BITS-1:0];
  assign b_prio     = rd_b_r[PRIORITY_BITS-1:0];
  assign parent_idx = (hole_r - ADDR_W'(1)) >> 1;
  assign left_w     = IDX_W'({hole_r, 1'b1});
  assign right_w    = left_w + IDX_W'(1);
  assign total_w    = IDX_W'(total_r);
  assign last_w     = total_w - IDX_W'(1);
  assign right_ok   = right_w < total_w;
  assign take_left  = a_prio < move_prio;
  assign min_prio   = take_left ? a_prio : move_prio;
  assign take_right = right_ok && (b_prio < min_prio);
  assign child      = take_right ? rd_b_r : rd_a_r;
  assign child_idx  = take_right ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    if (cmd.pop_read) begin
      raddr_a = '0;
      raddr_b = last_w[ADDR_W-1:0];
    end else if (cmd.up_read) begin
      raddr_a = parent_idx;
    end else if (cmd.down_read) begin
      raddr_a = left_w[ADDR_W-1:0];
      raddr_b = right_w[ADDR_W-1:0];
    end
  end

  always_comb begin
    mem_we    = cmd.place || cmd.up_move || cmd.down_move;
    mem_wdata = move_r;
    if (cmd.up_move) begin
      mem_wdata = rd_a_r;
    end else if (cmd.down_move) begin
      mem_wdata = child;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[hole_r] <= mem_wdata;
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  always_comb begin
    total_nxt = total_r;
    if (cmd.push_init) begin
      total_nxt = total_r + CNT_W'(1);
    end else if (cmd.pop_load) begin
      total_nxt = total_r - CNT_W'(1);
    end
  end

  always_comb begin
    hole_nxt = hole_r;
    if (cmd.push_init) begin
      hole_nxt = total_r[ADDR_W-1:0];
    end else if (cmd.pop_load) begin
      hole_nxt = '0;
    end else if (cmd.up_move) begin
      hole_nxt = parent_idx;
    end else if (cmd.down_move) begin
      hole_nxt = child_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      total_r <= total_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hole_r <= hole_nxt;
    if (cmd.latch_in) begin
      move_r     <= {in_request_id, in_request_priority};
      cmd_pop_r  <= in_command;
      res_id_r   <= '0;
      res_prio_r <= '0;
    end else if (cmd.pop_load) begin
      move_r     <= rd_b_r;
      res_id_r   <= rd_a_r[ENTRY_W-1:PRIORITY_BITS];
      res_prio_r <= a_prio;
    end
    if (cmd.set_status) res_status_r <= cmd.status_code;
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_prio_r   <= res_prio_r;
      out_count_r  <= COUNT_W'(total_r);
    end
  end

  always_comb begin
    stat                = '0;
    stat.cmd_pop        = (cmd_pop_r == CMD_POP);
    stat.full           = (CMP_W'(total_r) >= CMP_W'(limit_r)) ||
                          (CMP_W'(total_r) >= CMP_W'(CAPACITY));
    stat.empty          = (total_r == '0);
    stat.at_root        = (hole_r == '0);
    stat.parent_greater = a_prio > move_prio;
    stat.last_one       = (total_r == CNT_W'(1));
    stat.no_child       = left_w >= total_w;
    stat.down_stay      = !take_left && !take_right;
    stat.out_free       = !out_valid_r || out_ready;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_popped_id       = out_id_r;
  assign out_popped_priority = out_prio_r;
  assign out_entry_count     = out_count_r;

endmodule
